// ----- src/phtl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phtl_pkg
// Shared types and codes for the probed hash table: slot layout, item kinds,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package phtl_pkg;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // stored slot: lock word, evaluation, side-to-move tag
  typedef struct packed {
    logic [31:0] lock;
    logic [15:0] eval;
    logic [1:0]  color;
  } phtl_slot_t;

  localparam int unsigned SLOT_W = $bits(phtl_slot_t);

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_RESP  = 4'b1000
  } phtl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;      // latch incoming transaction, start at first slot
    logic clear;       // write zero at the clear pointer and advance it
    logic probe_next;  // move to the next slot of the window
    logic write_slot;  // store the item into the current slot
    logic record_hit;  // capture the hit, and for a lookup the evaluation, of the current slot
    logic load_out;    // move the result into the output register
  } phtl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_lock_zero;  // incoming item carries an empty-marker lock
    logic is_insert;     // item in flight is an insert
    logic slot_match;    // current slot satisfies the item
    logic last_probe;    // current slot is the last one of the window
    logic clear_done;    // clear pointer is at the top of the store
    logic out_free;      // output register can take a result this cycle
  } phtl_status_t;

endpackage
`default_nettype wire

// ----- src/phtl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phtl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module phtl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
`default_nettype wire

// ----- src/phtl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phtl_dp
// Datapath: item registers, probe index, clear pointer, slot RAM, slot
// compare and the output register.
// ----------------------------------------------------------------------------
module phtl_dp
  import phtl_pkg::*;
#(
  parameter int unsigned TABLE_SIZE   = 65536,
  parameter int unsigned PROBE_WINDOW = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               kind_i,
  input  wire logic [31:0]        key_i,
  input  wire logic [31:0]        lock_i,
  input  wire logic [1:0]         color_i,
  input  wire logic signed [15:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic signed [15:0]      eval_out_o,
  input  wire phtl_cmd_t          cmd_i,
  output phtl_status_t            status_o
);

  localparam int unsigned DEPTH  = TABLE_SIZE + PROBE_WINDOW;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned HOME_W = $clog2(TABLE_SIZE);
  localparam int unsigned IDX_W  = $clog2(PROBE_WINDOW + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(PROBE_WINDOW - 1);
  localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(DEPTH - 1);

  // item registers
  logic              kind_q;
  logic [HOME_W-1:0] base_q;
  logic [31:0]       lock_q;
  logic [1:0]        color_q;
  logic [15:0]       value_q;

  // probe and clear control
  logic [IDX_W-1:0]  idx_q;
  logic [ADDR_W-1:0] clr_q;

  // result and output registers
  logic        res_hit_q;
  logic [15:0] res_eval_q;
  logic        out_valid_q;
  logic        out_hit_q;
  logic [15:0] out_eval_q;

  // memory signals
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  phtl_slot_t        wr_slot;
  logic [ADDR_W-1:0] rd_addr;
  logic [SLOT_W-1:0] rd_data;
  phtl_slot_t        rd_slot;
  logic [IDX_W-1:0]  next_idx;
  logic [ADDR_W-1:0] cur_addr;
  logic              last_probe;
  logic              slot_match;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      base_q  <= key_i[HOME_W-1:0];
      lock_q  <= lock_i;
      color_q <= color_i;
      value_q <= value_i;
    end
  end

  // probe index and clear pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        idx_q <= '0;
      end else if (cmd_i.probe_next) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  // slot addressing; the next slot is read while the current one is checked
  assign last_probe = (idx_q == LAST_IDX);
  assign next_idx   = last_probe ? idx_q : idx_q + IDX_W'(1);
  assign cur_addr   = ADDR_W'(base_q) + ADDR_W'(idx_q);

  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = ADDR_W'(key_i[HOME_W-1:0]);
    end else begin
      rd_addr = ADDR_W'(base_q) + ADDR_W'(next_idx);
    end
  end

  // write port: clearing pass or insert
  always_comb begin
    wr_en = cmd_i.clear | cmd_i.write_slot;
    if (cmd_i.clear) begin
      wr_addr = clr_q;
      wr_slot = '0;
    end else begin
      wr_addr       = cur_addr;
      wr_slot.lock  = lock_q;
      wr_slot.eval  = value_q;
      wr_slot.color = color_q;
    end
  end

  phtl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_slot),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_slot = phtl_slot_t'(rd_data);

  // slot compare: empty slot for insert, lock and color for lookup
  always_comb begin
    if (kind_q == KIND_INSERT) begin
      slot_match = (rd_slot.lock == 32'd0);
    end else begin
      slot_match = (rd_slot.lock == lock_q) && (rd_slot.color == color_q);
    end
  end

  // result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_hit_q  <= 1'b0;
      res_eval_q <= '0;
    end else if (cmd_i.record_hit) begin
      res_hit_q  <= 1'b1;
      res_eval_q <= (kind_q == KIND_LOOKUP) ? rd_slot.eval : 16'd0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q  <= res_hit_q;
      out_eval_q <= res_eval_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign eval_out_o  = signed'(out_eval_q);

  // status to the controller
  assign status_o.in_lock_zero = (lock_i == 32'd0);
  assign status_o.is_insert    = (kind_q == KIND_INSERT);
  assign status_o.slot_match   = slot_match;
  assign status_o.last_probe   = last_probe;
  assign status_o.clear_done   = (clr_q == TOP_ADDR);
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

`ifndef SYNTHESIS
  // a new result never overwrites one still waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled result");

  // inserts only land in empty slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_slot |-> (rd_slot.lock == 32'd0) && (lock_q != 32'd0))
    else $error("insert would overwrite a used slot");

  // probe index stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX)
    else $error("probe index beyond window");

  // a lookup hit matches a used slot with the same lock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.record_hit && kind_q == KIND_LOOKUP) |=>
      res_hit_q && (lock_q != 32'd0) && ($past(rd_slot.lock) == lock_q))
    else $error("lookup hit on a mismatching slot");
`endif

endmodule
`default_nettype wire

// ----- src/phtl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phtl_ctrl
// Controller: clearing pass after reset, then accept, probe the window one
// slot per cycle and hand the result to the output register.
// ----------------------------------------------------------------------------
module phtl_ctrl
  import phtl_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire phtl_status_t status_i,
  output phtl_cmd_t         cmd_o
);

  phtl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.in_lock_zero ? ST_RESP : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status_i.slot_match) begin
          cmd_o.record_hit = 1'b1;
          cmd_o.write_slot = status_i.is_insert;
          state_d          = ST_RESP;
        end else if (status_i.last_probe) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  // the clearing pass ends before any transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> !cmd_o.clear && (state_q == ST_IDLE))
    else $error("transaction accepted during clearing pass");

  // a slot write always ends the probe and produces a result next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_slot |=> (state_q == ST_RESP))
    else $error("insert write not followed by result");

  // a result load returns to idle, so each accepted transaction yields one load before the next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (state_q == ST_IDLE))
    else $error("result load without return to idle");
`endif

endmodule
`default_nettype wire

// ----- src/probed_hash_table_insert_lookup.sv -----
// Flow: accept, probe the window slot by slot, load the result into the output register
// when it is free; a zero-lock item skips the probe. One slot of the single RAM read port
// per cycle. A new item is taken only after the last result has been loaded.
// Reset: after rst_ni is released, a clearing pass writes all TABLE_SIZE + PROBE_WINDOW
// slots to zero, one per cycle, with in_stall_o held high until it ends.
`default_nettype none
// ----------------------------------------------------------------------------
// probed_hash_table_insert_lookup
// Hash table with bounded linear probing: inserts into the first empty slot
// of the window, lookups return the first slot matching lock and color.
// ----------------------------------------------------------------------------
module probed_hash_table_insert_lookup
  import phtl_pkg::*;
#(
  parameter int unsigned TABLE_SIZE   = 65536,
  parameter int unsigned PROBE_WINDOW = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [31:0]        key_i,
  input  wire logic [31:0]        lock_i,
  input  wire logic [1:0]         color_i,
  input  wire logic signed [15:0] value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic signed [15:0]      eval_out_o
);

  phtl_cmd_t    cmd;
  phtl_status_t status;

  // controller
  phtl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  phtl_dp #(
    .TABLE_SIZE   (TABLE_SIZE),
    .PROBE_WINDOW (PROBE_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .lock_i      (lock_i),
    .color_i     (color_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .eval_out_o  (eval_out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
`default_nettype wire

// ----- test/probed_hash_table_insert_lookup_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// probed_hash_table_insert_lookup_tb
// Self-checking bench for the probed hash table. A directed table covers the
// empty table, extreme fields, zero locks, full windows at the top of the
// store and duplicate entries. Random traffic follows, aimed at a few
// clustered home slots so that windows overlap, fill up and get looked up.
// Results are checked against listed answers or a mirror of the slot store.
// ----------------------------------------------------------------------------
module probed_hash_table_insert_lookup_tb
  import phtl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SIZE   = 65536;
  localparam int unsigned PROBE_WINDOW = 4;
  localparam int unsigned STORE_DEPTH  = TABLE_SIZE + PROBE_WINDOW;

  localparam int N_DIRECTED       = 25;
  localparam int RANDOM_PER_PHASE = 382;
  localparam int HOLD_LEN         = 300;
  localparam int DRAIN_CYCLES     = 20;

  // idling per phase: none, sender, receiver, both
  localparam int IDLE_PCT [4] = '{0, 83, 0, 27};
  localparam int STALL_PCT [4] = '{0, 0, 83, 27};
  // home-slot clusters per phase, the last one runs into the top of the store
  localparam logic [15:0] CLUSTER_BASE [4] = '{16'h0040, 16'h7F00, 16'hC000, 16'hFFC0};

  typedef struct packed {
    logic        hit;
    logic signed [15:0] eval;
  } probe_answer_t;

  typedef struct packed {
    logic [15:0] home;
    logic [31:0] lock;
    logic [1:0]  color;
  } entry_tag_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        key;
    logic [31:0]        lock;
    logic [1:0]         color;
    logic signed [15:0] value;
    logic               typed;
    logic               hit;
    logic signed [15:0] eval;
  } stim_row_t;

  // directed rows: kind, key, lock, color, value, typed, hit, eval
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // empty table after reset
    '{KIND_LOOKUP, 32'h0000_0000, 32'h0000_0001, 2'd0, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 2'd3, 16'h8000, 1'b1, 1'b1, 16'h0000},
    // upper key bits do not take part in the home slot
    '{KIND_LOOKUP, 32'hABCD_0000, 32'hFFFF_FFFF, 2'd3, 16'h1234, 1'b1, 1'b1, 16'h8000},
    // color mismatch
    '{KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 2'd2, 16'h0000, 1'b1, 1'b0, 16'h0000},
    // zero lock insert is dropped, zero lock lookup never hits an empty slot
    '{KIND_INSERT, 32'h0000_0010, 32'h0000_0000, 2'd1, 16'h004D, 1'b1, 1'b0, 16'h0000},
    '{KIND_LOOKUP, 32'h0000_0010, 32'h0000_0000, 2'd0, 16'h0000, 1'b1, 1'b0, 16'h0000},
    // fill the window at the last home slot, spilling into the extra slots
    '{KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 2'd0, 16'h7FFF, 1'b1, 1'b1, 16'h0000},
    '{KIND_INSERT, 32'h1234_FFFF, 32'h8000_0000, 2'd1, 16'hFFFF, 1'b1, 1'b1, 16'h0000},
    '{KIND_INSERT, 32'h0000_FFFF, 32'h5555_5555, 2'd2, 16'h0000, 1'b1, 1'b1, 16'h0000},
    '{KIND_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 2'd3, 16'h0001, 1'b1, 1'b1, 16'h0000},
    // window full
    '{KIND_INSERT, 32'h0000_FFFF, 32'h0F0F_0F0F, 2'd0, 16'h0063, 1'b1, 1'b0, 16'h0000},
    '{KIND_LOOKUP, 32'h7777_FFFF, 32'hAAAA_AAAA, 2'd3, 16'h0000, 1'b1, 1'b1, 16'h0001},
    '{KIND_LOOKUP, 32'h0000_FFFF, 32'h0000_0001, 2'd0, 16'hFFFF, 1'b1, 1'b1, 16'h7FFF},
    '{KIND_LOOKUP, 32'h0000_FFFF, 32'h0F0F_0F0F, 2'd0, 16'h0000, 1'b1, 1'b0, 16'h0000},
    // overlapping windows near the top
    '{KIND_INSERT, 32'h0000_FFFE, 32'h0000_0002, 2'd1, 16'h03E8, 1'b0, 1'b0, 16'h0000},
    '{KIND_LOOKUP, 32'h0000_FFFD, 32'h5555_5555, 2'd2, 16'h0000, 1'b0, 1'b0, 16'h0000},
    // duplicate insert takes the next slot, lookup sees the first one
    '{KIND_INSERT, 32'h0000_0100, 32'h1357_9BDF, 2'd1, 16'h0005, 1'b1, 1'b1, 16'h0000},
    '{KIND_INSERT, 32'h0000_0100, 32'h1357_9BDF, 2'd1, 16'h0007, 1'b1, 1'b1, 16'h0000},
    '{KIND_LOOKUP, 32'h0000_0100, 32'h1357_9BDF, 2'd1, 16'h0000, 1'b1, 1'b1, 16'h0005},
    '{KIND_LOOKUP, 32'h0000_0101, 32'h1357_9BDF, 2'd1, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{KIND_LOOKUP, 32'h0000_00FF, 32'h1357_9BDF, 2'd1, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{KIND_INSERT, 32'h0000_0101, 32'h2468_ACE0, 2'd2, 16'hFED4, 1'b0, 1'b0, 16'h0000},
    '{KIND_INSERT, 32'h0000_0100, 32'h0000_0001, 2'd0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{KIND_INSERT, 32'h0000_0100, 32'h0000_0003, 2'd0, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 2'd3, 16'h7FFF, 1'b1, 1'b1, 16'h8000}
  };

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               kind_i      = KIND_INSERT;
  logic [31:0]        key_i       = '0;
  logic [31:0]        lock_i      = '0;
  logic [1:0]         color_i     = '0;
  logic signed [15:0] value_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic signed [15:0] eval_out_o;

  // mirror of the slot store and the answers still in flight
  phtl_slot_t    slot_mirror [STORE_DEPTH];
  probe_answer_t answer_q [$];
  entry_tag_t    stored_tags [$];

  int  idle_pct     = 0;
  int  stall_pct    = 0;
  logic hold_go     = 1'b0;
  int  mismatch_cnt = 0;
  int  result_cnt   = 0;
  int  n_inserts    = 0;
  int  n_placed     = 0;
  int  n_full       = 0;
  int  n_lookups    = 0;
  int  n_found      = 0;

  probed_hash_table_insert_lookup #(
    .TABLE_SIZE  (TABLE_SIZE),
    .PROBE_WINDOW(PROBE_WINDOW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .key_i      (key_i),
    .lock_i     (lock_i),
    .color_i    (color_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hit_o      (hit_o),
    .eval_out_o (eval_out_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // insert into first empty slot or look up first matching slot of the window
  function automatic probe_answer_t table_access(input logic kind, input logic [31:0] key,
                                                 input logic [31:0] lock,
                                                 input logic [1:0] color,
                                                 input logic signed [15:0] value);
    probe_answer_t ans;
    int unsigned   idx;
    int unsigned   i;
    ans = '0;
    if (lock != '0) begin
      for (i = 0; i < PROBE_WINDOW; i++) begin
        idx = (key % TABLE_SIZE) + i;
        if (idx >= STORE_DEPTH) break;
        if (kind == KIND_INSERT) begin
          if (slot_mirror[idx].lock == '0) begin
            slot_mirror[idx].lock  = lock;
            slot_mirror[idx].eval  = value;
            slot_mirror[idx].color = color;
            ans.hit = 1'b1;
            break;
          end
        end else if (slot_mirror[idx].lock == lock && slot_mirror[idx].color == color) begin
          ans.hit  = 1'b1;
          ans.eval = slot_mirror[idx].eval;
          break;
        end
      end
    end
    return ans;
  endfunction

  // offer one transaction, predict its answer once it is taken
  task automatic send_item(input stim_row_t row);
    probe_answer_t ans;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= row.kind;
    key_i      <= row.key;
    lock_i     <= row.lock;
    color_i    <= row.color;
    value_i    <= row.value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ans = table_access(row.kind, row.key, row.lock, row.color, row.value);
    if (row.kind == KIND_INSERT) begin
      n_inserts++;
      if (ans.hit) n_placed++;
      else if (row.lock != '0) n_full++;
      if (row.lock != '0) stored_tags.push_back({row.key[15:0], row.lock, row.color});
    end else begin
      n_lookups++;
      if (ans.hit) n_found++;
    end
    if (row.typed) answer_q.push_back({row.hit, row.eval});
    else answer_q.push_back(ans);
  endtask

  // random transaction, mostly aimed at one cluster of home slots
  task automatic send_random(input logic [15:0] base);
    stim_row_t  row;
    entry_tag_t tag;
    int         pick;
    row       = '0;
    row.kind  = logic'($urandom_range(0, 1));
    row.key   = $urandom;
    row.lock  = $urandom;
    row.color = 2'($urandom_range(0, 3));
    row.value = 16'($urandom);
    if ($urandom_range(0, 9) != 0) row.key[15:0] = base + 16'($urandom_range(0, 63));
    tag  = '0;
    if (stored_tags.size() != 0) tag = stored_tags[$urandom_range(0, stored_tags.size() - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      row.lock = '0;
    end else if (stored_tags.size() != 0) begin
      if (row.kind == KIND_INSERT && pick < 15) begin
        // duplicate of an earlier entry
        row.key[15:0] = tag.home;
        row.lock      = tag.lock;
        row.color     = tag.color;
      end else if (row.kind == KIND_LOOKUP && pick < 80) begin
        row.key[15:0] = tag.home - 16'($urandom_range(0, 1));
        row.lock      = tag.lock;
        row.color     = tag.color;
        if (pick >= 65) row.color = tag.color + 2'($urandom_range(1, 3));
      end
    end
    send_item(row);
  endtask

  // receiver: one long hold-off when asked, otherwise random stalls
  initial begin : sink_side
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && held < HOLD_LEN) begin
        out_stall_i <= 1'b1;
        held++;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest answer
  always @(posedge clk_i) begin : result_check
    probe_answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (answer_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: hit %0b eval %0d", hit_o, eval_out_o);
      end else begin
        want = answer_q.pop_front();
        if (hit_o !== want.hit || eval_out_o !== want.eval) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected hit %0b eval %0d, got hit %0b eval %0d",
                     result_cnt, want.hit, want.eval, hit_o, eval_out_o);
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    int ph;
    int n;
    foreach (slot_mirror[j]) slot_mirror[j] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (n = 0; n < N_DIRECTED; n++) send_item(DIRECTED_ROWS[n]);

    // random phases with different idling
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      if (ph == 0) hold_go <= 1'b1;
      for (n = 0; n < RANDOM_PER_PHASE; n++) send_random(CLUSTER_BASE[ph]);
    end
    in_valid_i <= 1'b0;

    // drain
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts (%0d placed, %0d into full windows) and %0d lookups (%0d hits)",
             n_inserts, n_placed, n_full, n_lookups, n_found);
    $display("%0d results checked, %0d mismatches", result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && answer_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", answer_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
src/phtl_pkg.sv
src/phtl_ram.sv
src/phtl_dp.sv
src/phtl_ctrl.sv
src/probed_hash_table_insert_lookup.sv
test/probed_hash_table_insert_lookup_tb.sv
